// ----- hw/rtl/sks_pkg.sv -----
// ----------------------------------------------------------------------------
// sks_pkg
// Types and constants shared by the serial key scancode queue modules.
// ----------------------------------------------------------------------------
package sks_pkg;

  // field widths
  localparam int unsigned CODE_W   = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned LEVEL_W  = 6;
  localparam int unsigned TBL_AW   = 7;
  localparam int unsigned TBL_DEPTH = 128;

  // op queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // command codes
  localparam logic [1:0] CMD_RX  = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_MAP = 2'd2;

  // special bytes and codes
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CODE_SHIFT = 7'h2A;

  // request fields
  typedef struct packed {
    logic [1:0]        cmd;
    logic              rx_ready;
    logic              rx_error;
    logic [BYTE_W-1:0] rx_byte;
    logic [TBL_AW-1:0] map_index;
    logic [BYTE_W-1:0] map_value;
  } req_t;

  // result fields
  typedef struct packed {
    logic [CODE_W-1:0]  scancode;
    logic [CNT_W-1:0]   rx_count;
    logic [CNT_W-1:0]   error_count;
    logic [CNT_W-1:0]   drop_count;
    logic [CNT_W-1:0]   push_count;
    logic [LEVEL_W-1:0] ring_level;
  } res_t;

  // operations handed from front to back
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_REPORT
  } op_e;

  typedef struct packed {
    op_e               kind;
    logic [CODE_W-1:0] code;
  } op_t;

  // front sequencer
  typedef enum logic [2:0] {
    F_IDLE,
    F_LOOK,
    F_CODE,
    F_SHIFT,
    F_FINAL,
    F_WAIT
  } front_state_e;

  // status from front
  typedef struct packed {
    logic [CNT_W-1:0] rx_count;
    logic [CNT_W-1:0] error_count;
  } front_stat_t;

  // status from back
  typedef struct packed {
    logic [CNT_W-1:0]   drop_count;
    logic [CNT_W-1:0]   push_count;
    logic [LEVEL_W-1:0] ring_level;
  } back_stat_t;

endpackage

// ----- hw/rtl/sks_op_queue.sv -----
// ----------------------------------------------------------------------------
// sks_op_queue
// Small op queue between the front classifier and the back ring engine.
// ----------------------------------------------------------------------------
module sks_op_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sks_pkg::op_t   data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sks_pkg::op_t   data_o
);

  sks_pkg::op_t                  slot_q [sks_pkg::QUEUE_DEPTH];
  logic [sks_pkg::QPTR_W-1:0]    wptr_q, wptr_d;
  logic [sks_pkg::QPTR_W-1:0]    rptr_q, rptr_d;
  logic [sks_pkg::QPTR_W:0]      cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == (sks_pkg::QPTR_W+1)'(sks_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/sks_front.sv -----
// ----------------------------------------------------------------------------
// sks_front
// Accepts requests, keeps the receive counters and the keymap, and turns
// each request into ring operations for the back end.
// ----------------------------------------------------------------------------
module sks_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  sks_pkg::req_t             req_i,
  output logic                      busy_o,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_data_i,
  output logic                      cfg_ready_o,
  input  logic                      done_i,
  output logic                      q_push_o,
  output sks_pkg::op_t              q_data_o,
  input  logic                      q_full_i,
  output logic                      ring_clear_o,
  output sks_pkg::front_stat_t      stat_o
);

  sks_pkg::front_state_e           state_q, state_d;
  logic                            enable_q;
  logic [sks_pkg::BYTE_W-1:0]      prev_q;
  logic [sks_pkg::CNT_W-1:0]       rx_cnt_q, err_cnt_q;
  logic                            look_q;
  sks_pkg::op_e                    final_q;
  logic [sks_pkg::BYTE_W-1:0]      tbl_mem [sks_pkg::TBL_DEPTH];
  logic [sks_pkg::TBL_DEPTH-1:0]   tbl_vld_q;
  logic [sks_pkg::BYTE_W-1:0]      tbl_rd_q;
  logic                            tbl_rv_q;
  logic [sks_pkg::BYTE_W-1:0]      entry;
  logic                            accept, cfg_wr, rx_live, map_wr;

  assign busy_o       = (state_q != sks_pkg::F_IDLE);
  // no register write in the cycle a request is offered
  assign cfg_ready_o  = !busy_o && !start_i;
  assign accept       = start_i && !busy_o;
  assign cfg_wr       = cfg_valid_i && cfg_ready_o;
  assign ring_clear_o = cfg_wr && cfg_data_i;
  assign rx_live      = accept && enable_q && (req_i.cmd == sks_pkg::CMD_RX);
  assign map_wr       = accept && (req_i.cmd == sks_pkg::CMD_MAP);
  assign entry        = tbl_rv_q ? tbl_rd_q : '0;

  assign stat_o.rx_count    = rx_cnt_q;
  assign stat_o.error_count = err_cnt_q;

  // control registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sks_pkg::F_IDLE;
      enable_q  <= 1'b0;
      prev_q    <= '0;
      rx_cnt_q  <= '0;
      err_cnt_q <= '0;
      look_q    <= 1'b0;
      final_q   <= sks_pkg::OP_REPORT;
      tbl_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        enable_q <= cfg_data_i;
      end
      if (map_wr) begin
        tbl_vld_q[req_i.map_index] <= 1'b1;
      end
      if (accept) begin
        final_q <= (req_i.cmd == sks_pkg::CMD_POP) ? sks_pkg::OP_POP : sks_pkg::OP_REPORT;
        // lf right after cr and bytes above ascii are not mapped
        look_q  <= rx_live && req_i.rx_ready
                   && !((req_i.rx_byte == sks_pkg::BYTE_LF) && (prev_q == sks_pkg::BYTE_CR))
                   && !req_i.rx_byte[sks_pkg::BYTE_W-1];
      end
      if (rx_live) begin
        if (req_i.rx_error) begin
          err_cnt_q <= err_cnt_q + 1'b1;
        end
        if (req_i.rx_ready) begin
          rx_cnt_q <= rx_cnt_q + 1'b1;
          prev_q   <= req_i.rx_byte;
        end
      end
    end
  end

  // keymap storage, write on map request, registered read on receive
  always_ff @(posedge clk_i) begin
    if (map_wr) begin
      tbl_mem[req_i.map_index] <= req_i.map_value;
    end
    if (rx_live) begin
      tbl_rd_q <= tbl_mem[req_i.rx_byte[sks_pkg::TBL_AW-1:0]];
      tbl_rv_q <= tbl_vld_q[req_i.rx_byte[sks_pkg::TBL_AW-1:0]];
    end
  end

  // sequencer: emit push ops then the closing op
  always_comb begin
    state_d  = state_q;
    q_push_o = 1'b0;
    q_data_o = '{kind: final_q, code: '0};
    case (state_q)
      sks_pkg::F_IDLE: begin
        if (accept) begin
          state_d = sks_pkg::F_LOOK;
        end
      end
      sks_pkg::F_LOOK: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          if (look_q && (entry != '0)) begin
            if (entry[sks_pkg::BYTE_W-1]) begin
              q_data_o = '{kind: sks_pkg::OP_PUSH, code: sks_pkg::CODE_SHIFT};
              state_d  = sks_pkg::F_CODE;
            end else begin
              q_data_o = '{kind: sks_pkg::OP_PUSH, code: entry[sks_pkg::CODE_W-1:0]};
              state_d  = sks_pkg::F_FINAL;
            end
          end else begin
            state_d = sks_pkg::F_WAIT;
          end
        end
      end
      sks_pkg::F_CODE: begin
        q_data_o = '{kind: sks_pkg::OP_PUSH, code: entry[sks_pkg::CODE_W-1:0]};
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = sks_pkg::F_SHIFT;
        end
      end
      sks_pkg::F_SHIFT: begin
        q_data_o = '{kind: sks_pkg::OP_PUSH, code: sks_pkg::CODE_SHIFT};
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = sks_pkg::F_FINAL;
        end
      end
      sks_pkg::F_FINAL: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = sks_pkg::F_WAIT;
        end
      end
      sks_pkg::F_WAIT: begin
        if (done_i) begin
          state_d = sks_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = sks_pkg::F_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/sks_back.sv -----
// ----------------------------------------------------------------------------
// sks_back
// Ring engine: executes push and pop ops on the code ring, one op a cycle,
// and raises the result strobe on the closing op of each request.
// ----------------------------------------------------------------------------
module sks_back #(
  parameter int unsigned RING_SLOTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  sks_pkg::op_t                      q_data_i,
  output logic                              q_pop_o,
  input  logic                              ring_clear_i,
  output logic                              done_o,
  output logic [sks_pkg::CODE_W-1:0]        scancode_o,
  output sks_pkg::back_stat_t               stat_o
);

  localparam int unsigned PTR_W = $clog2(RING_SLOTS);
  localparam int unsigned LW    = (PTR_W + 1 > sks_pkg::LEVEL_W) ? PTR_W + 1 : sks_pkg::LEVEL_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_SLOTS - 1);

  logic [sks_pkg::CODE_W-1:0]  ring_mem [RING_SLOTS];
  logic [PTR_W-1:0]            wptr_q, rptr_q, wnext, rnext;
  logic [sks_pkg::CNT_W-1:0]   drop_q, push_q;
  logic [sks_pkg::CODE_W-1:0]  rd_q;
  logic                        hit_q, done_q;
  logic                        fire, ring_full, ring_empty, do_write, do_read;
  logic [LW-1:0]               level;

  assign fire       = !q_empty_i;
  assign q_pop_o    = fire;
  assign wnext      = (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
  assign rnext      = (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
  assign ring_full  = (wnext == rptr_q);
  assign ring_empty = (wptr_q == rptr_q);
  assign do_write   = fire && (q_data_i.kind == sks_pkg::OP_PUSH) && !ring_full;
  assign do_read    = fire && (q_data_i.kind == sks_pkg::OP_POP) && !ring_empty;

  // occupancy, wrapped around the ring size
  assign level = LW'(wptr_q) - LW'(rptr_q) + ((wptr_q < rptr_q) ? LW'(RING_SLOTS) : '0);

  assign done_o            = done_q;
  assign scancode_o        = hit_q ? rd_q : '0;
  assign stat_o.drop_count = drop_q;
  assign stat_o.push_count = push_q;
  assign stat_o.ring_level = level[sks_pkg::LEVEL_W-1:0];

  // pointers, counters and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      drop_q <= '0;
      push_q <= '0;
      hit_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fire && (q_data_i.kind != sks_pkg::OP_PUSH);
      // code shown only right after a pop that found one
      hit_q  <= do_read;
      if (ring_clear_i) begin
        wptr_q <= '0;
        rptr_q <= '0;
      end else begin
        if (fire && (q_data_i.kind == sks_pkg::OP_PUSH)) begin
          if (ring_full) begin
            drop_q <= drop_q + 1'b1;
          end else begin
            wptr_q <= wnext;
            push_q <= push_q + 1'b1;
          end
        end
        if (do_read) begin
          rptr_q <= rnext;
        end
      end
    end
  end

  // code ring storage with registered read
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      ring_mem[wptr_q] <= q_data_i.code;
    end
    if (do_read) begin
      rd_q <= ring_mem[rptr_q];
    end
  end

endmodule

// ----- hw/rtl/serial_key_scancode_queue.sv -----
// ----------------------------------------------------------------------------
// serial_key_scancode_queue
// Serial keyboard scancode queue: maps received bytes to scancodes and
// holds them in a ring that is read one code per pop request.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o then
// stays high until the single result has been shown for one cycle with
// done_o, and the next request can be taken in the cycle after that.
// The result cannot be held off, so sample res_o whenever done_o is high.
// A pop, a keymap write or an unmapped byte passes only its closing op to the
// ring engine; a plain key sends one push op before it and a shifted key
// three (shift, code, shift). The front sequencer issues one ring op per
// cycle into the op queue while the queue is not full, and the ring engine
// executes one op per cycle on the single-port code ring.
// Configuration writes are taken whenever no request is in flight or being
// offered on start_i; writing enable as one empties the ring.
// ----------------------------------------------------------------------------
module serial_key_scancode_queue #(
  parameter int unsigned RING_SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sks_pkg::req_t    req_i,
  output logic             busy_o,
  output logic             done_o,
  output sks_pkg::res_t    res_o,
  input  logic             cfg_valid_i,
  input  logic             cfg_data_i,
  output logic             cfg_ready_o
);

  logic                         q_push, q_full, q_pop, q_empty, ring_clear, back_done;
  sks_pkg::op_t                 q_in, q_out;
  sks_pkg::front_stat_t         fstat;
  sks_pkg::back_stat_t          bstat;
  logic [sks_pkg::CODE_W-1:0]   scancode;

  // request intake and classification
  sks_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .busy_o       (busy_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_ready_o  (cfg_ready_o),
    .done_i       (back_done),
    .q_push_o     (q_push),
    .q_data_o     (q_in),
    .q_full_i     (q_full),
    .ring_clear_o (ring_clear),
    .stat_o       (fstat)
  );

  // op queue
  sks_op_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  // ring engine
  sks_back #(
    .RING_SLOTS (RING_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_out),
    .q_pop_o      (q_pop),
    .ring_clear_i (ring_clear),
    .done_o       (back_done),
    .scancode_o   (scancode),
    .stat_o       (bstat)
  );

  // result assembly
  assign done_o            = back_done;
  assign res_o.scancode    = scancode;
  assign res_o.rx_count    = fstat.rx_count;
  assign res_o.error_count = fstat.error_count;
  assign res_o.drop_count  = bstat.drop_count;
  assign res_o.push_count  = bstat.push_count;
  assign res_o.ring_level  = bstat.ring_level;

endmodule

// ----- hw/rtl/sks_checker.sv -----
// ----------------------------------------------------------------------------
// sks_checker
// Port-level checks on request and result sequencing of the scancode queue.
// ----------------------------------------------------------------------------
module sks_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_o,
  input  logic          done_o,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_o
);

  // a result only appears while a request is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_o)
    else $error("result strobe without request in flight");

  // a taken request keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start_i && !busy_o) |=> busy_o)
    else $error("request taken but block not busy");

  // the result closes the request
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> (!busy_o && !done_o))
    else $error("request not closed after its result");

  // configuration is only taken between requests
  assert property (@(posedge clk_i) disable iff (!rst_ni) (cfg_valid_i && cfg_ready_o) |-> !busy_o)
    else $error("configuration taken while busy");

endmodule

bind serial_key_scancode_queue sks_checker u_sks_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
